### hdl/biquad_cascade_bandpass_defines.svh
// ----------------------------------------------------------------------------
// biquad_cascade_bandpass_defines.svh
// Assertion macros for the biquad cascade band-pass filter.
// ----------------------------------------------------------------------------
`ifndef BIQUAD_CASCADE_BANDPASS_DEFINES_SVH
`define BIQUAD_CASCADE_BANDPASS_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked out of reset
`define BQC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked out of reset
`define BQC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BQC_ASSERT_IMP(lbl, ante, cons, msg)
`define BQC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### hdl/bqc_pkg.sv
// ----------------------------------------------------------------------------
// bqc_pkg
// Types, sizes and fixed coefficients of the biquad cascade band-pass filter.
// ----------------------------------------------------------------------------
package bqc_pkg;

    localparam int SECTIONS     = 4;
    localparam int SAMPLE_BITS  = 12;
    localparam int MAX_SECTIONS = 8;
    localparam int FRAC_BITS    = 16;
    localparam int COEF_FRAC    = 29;
    localparam int SEC_W        = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int DLY_N        = 2 * SECTIONS;

    typedef logic signed [31:0] coef_t;
    typedef logic signed [39:0] data_t;
    typedef logic signed [43:0] acc_t;

    // coefficient order inside a row: b0, b1, b2, a1, a2 (Q3.29)
    localparam int CF_B0 = 0;
    localparam int CF_B1 = 1;
    localparam int CF_B2 = 2;
    localparam int CF_A1 = 3;
    localparam int CF_A2 = 4;

    localparam coef_t COEF_TAB [MAX_SECTIONS][5] = '{
        '{32'sd3947515, 32'sd7895030, 32'sd3947515, -32'sd512128411, 32'sd135889308},
        '{32'sd536870912, 32'sd1073741824, 32'sd536870912, -32'sd647448227,
          32'sd325120069},
        '{32'sd536870912, -32'sd1073741824, 32'sd536870912, -32'sd1061343569,
          32'sd524557214},
        '{32'sd536870912, -32'sd1073741824, 32'sd536870912, -32'sd1068757982,
          32'sd531968277},
        '{32'sd536870912, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
        '{32'sd536870912, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
        '{32'sd536870912, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
        '{32'sd536870912, 32'sd0, 32'sd0, 32'sd0, 32'sd0}
    };

    localparam data_t DATA_MAX = {1'b0, {39{1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {39{1'b0}}};

    function automatic data_t sat40(input acc_t v);
        data_t r;
        if (v > 44'(DATA_MAX))
            r = DATA_MAX;
        else if (v < 44'(DATA_MIN))
            r = DATA_MIN;
        else
            r = v[39:0];
        return r;
    endfunction

endpackage

### hdl/biquad_cascade_bandpass.sv
// ----------------------------------------------------------------------------
// biquad_cascade_bandpass
// Eighth-order band-pass: cascaded direct-form-II biquads on one shared
// multiplier.
//
// Input channel (in_valid / in_ready / sample) takes one raw 12-bit converter
// reading per transaction. Output channel (out_valid / out_ready / filtered)
// returns one signed 14-bit result per sample, rounded and saturated.
// Each section forms five products (a1*d1, a2*d2, b0*w, b1*d1, b2*d2). Each
// product runs on the single 32x25 multiplier in phases: high partial,
// low partial, round, accumulate. in_ready is high only while the
// sequencer is idle, so the next sample can be accepted in the cycle
// after the result is loaded into the output register; a new sample is
// taken only once the previous one has been fully processed.
// The output register holds a result until it is taken; a new sample may
// still be accepted and processed, and its result waits in the last step
// until the output register is free.
// Reset clears all section delays to zero and empties the output register.
// ----------------------------------------------------------------------------
`include "biquad_cascade_bandpass_defines.svh"

module biquad_cascade_bandpass (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [11:0] sample,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [13:0] filtered
);
    import bqc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam logic [2:0] OP_A1 = 3'd0;
    localparam logic [2:0] OP_A2 = 3'd1;
    localparam logic [2:0] OP_B0 = 3'd2;
    localparam logic [2:0] OP_B1 = 3'd3;
    localparam logic [2:0] OP_B2 = 3'd4;

    localparam logic [1:0] PH_HI  = 2'd0;
    localparam logic [1:0] PH_LO  = 2'd1;
    localparam logic [1:0] PH_SUM = 2'd2;
    localparam logic [1:0] PH_ACC = 2'd3;

    localparam logic [11:0] SAMPLE_MASK = 12'((20'd1 << SAMPLE_BITS) - 20'd1);
    localparam logic signed [71:0] RND_HALF = 72'sd1 <<< (COEF_FRAC - 1);

    logic [1:0]       state_reg, state_next;
    logic [2:0]       op_reg;
    logic [1:0]       phase_reg;
    logic [SEC_W-1:0] sec_reg;
    data_t            dly_reg [DLY_N];
    data_t            x_reg;
    data_t            w_reg;
    acc_t             acc_reg;
    acc_t             rnd_reg;
    logic signed [56:0] mul_reg;
    logic signed [71:0] sum_reg;
    logic             out_valid_reg;
    logic signed [13:0] filtered_reg;

    logic             in_fire;
    logic             out_free;
    logic             sec_last;
    coef_t            coef_sel;
    data_t            data_sel;
    logic signed [24:0] mul_b;
    logic signed [56:0] mul_full;
    logic signed [71:0] sum_full;
    acc_t             acc_base;
    acc_t             acc_calc;
    data_t            acc_sat;
    logic signed [40:0] out_rnd;
    logic signed [24:0] out_int;
    logic signed [13:0] filtered_next;
    logic [2:0]       coef_col;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign sec_last  = (sec_reg == SEC_W'(SECTIONS - 1));
    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;

    // operand selection for the current product
    always_comb
    begin
        unique case (op_reg)
            OP_A1:   begin coef_col = 3'(CF_A1); data_sel = dly_reg[0]; end
            OP_A2:   begin coef_col = 3'(CF_A2); data_sel = dly_reg[1]; end
            OP_B0:   begin coef_col = 3'(CF_B0); data_sel = w_reg;      end
            OP_B1:   begin coef_col = 3'(CF_B1); data_sel = dly_reg[0]; end
            OP_B2:   begin coef_col = 3'(CF_B2); data_sel = dly_reg[1]; end
            default: begin coef_col = 3'(CF_B0); data_sel = w_reg;      end
        endcase
    end

    assign coef_sel = COEF_TAB[3'(sec_reg)][coef_col];

    // high phase multiplies the signed upper 24 bits, otherwise the low 16
    assign mul_b    = (phase_reg == PH_HI) ? {data_sel[39], data_sel[39:16]}
                                           : {9'd0, data_sel[15:0]};
    assign mul_full = coef_sel * mul_b;
    assign sum_full = sum_reg + 72'(mul_reg);

    always_comb
    begin
        case (op_reg)
            OP_A1:   acc_base = 44'(x_reg);
            OP_B0:   acc_base = '0;
            default: acc_base = acc_reg;
        endcase
        if (op_reg == OP_A1 || op_reg == OP_A2)
            acc_calc = acc_base - rnd_reg;
        else
            acc_calc = acc_base + rnd_reg;
        acc_sat = sat40(acc_calc);
    end

    // round the last section output to converter units
    always_comb
    begin
        out_rnd = 41'(x_reg) + (41'sd1 <<< (FRAC_BITS - 1));
        out_int = 25'(out_rnd >>> FRAC_BITS);
        if (out_int > 25'sd8191)
            filtered_next = 14'sd8191;
        else if (out_int < -25'sd8192)
            filtered_next = -14'sd8192;
        else
            filtered_next = out_int[13:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                    state_next = S_RUN;
            end
            S_RUN:
            begin
                if (phase_reg == PH_ACC && op_reg == OP_B2 && sec_last)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_A1;
            phase_reg     <= PH_HI;
            sec_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < DLY_N; i++)
                dly_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                op_reg    <= OP_A1;
                phase_reg <= PH_HI;
                sec_reg   <= '0;
            end
            else if (state_reg == S_RUN)
            begin
                phase_reg <= phase_reg + 2'd1;
                if (phase_reg == PH_ACC)
                begin
                    if (op_reg == OP_B2)
                    begin
                        op_reg <= OP_A1;
                        if (!sec_last)
                            sec_reg <= sec_reg + SEC_W'(1);
                        // rotate so the next section's delay pair sits at the head
                        for (int i = 0; i < DLY_N - 2; i++)
                            dly_reg[i] <= dly_reg[i + 2];
                        dly_reg[DLY_N - 2] <= w_reg;
                        dly_reg[DLY_N - 1] <= dly_reg[0];
                    end
                    else
                    begin
                        op_reg <= op_reg + 3'd1;
                    end
                end
            end

            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_fire)
            x_reg <= 40'(sample & SAMPLE_MASK) <<< FRAC_BITS;
        if (state_reg == S_RUN)
        begin
            unique case (phase_reg)
                PH_HI:
                begin
                    mul_reg <= mul_full;
                end
                PH_LO:
                begin
                    sum_reg <= (72'(mul_reg) <<< FRAC_BITS) + RND_HALF;
                    mul_reg <= mul_full;
                end
                PH_SUM:
                begin
                    rnd_reg <= 44'(sum_full >>> COEF_FRAC);
                end
                PH_ACC:
                begin
                    acc_reg <= acc_calc;
                    if (op_reg == OP_A2)
                        w_reg <= acc_sat;
                    if (op_reg == OP_B2)
                        x_reg <= acc_sat;
                end
                default: ;
            endcase
        end
        if (state_reg == S_DONE && out_free)
            filtered_reg <= filtered_next;
    end

    `BQC_ASSERT_NXT(a_start_clean, in_fire,
        state_reg == S_RUN && op_reg == OP_A1 && phase_reg == PH_HI && sec_reg == '0,
        "sequencer did not start at the first product of section zero")
    `BQC_ASSERT_IMP(a_op_range, state_reg == S_RUN,
        op_reg <= OP_B2 && sec_reg <= SEC_W'(SECTIONS - 1),
        "product or section counter out of range")
    `BQC_ASSERT_NXT(a_hold_result, state_reg == S_DONE && out_valid_reg && !out_ready,
        state_reg == S_DONE,
        "finished result left the done step while the output was blocked")
    `BQC_ASSERT_NXT(a_load_out, state_reg == S_DONE && out_free,
        out_valid_reg && state_reg == S_IDLE,
        "output register not loaded when the result was released")

endmodule
